@@ rtl/dnse_pkg.sv @@
`default_nettype none

package dnse_pkg;

    // field widths
    localparam int BYTE_W        = 8;
    localparam int CNT_W         = 6;
    localparam int LABEL_MAX_DEF = 63;
    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);

    // operation codes and the label separator
    localparam logic OP_NAME_BYTE = 1'b0;
    localparam logic OP_END       = 1'b1;
    localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;

    // input item
    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] name_byte;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              zero_follows;
        logic              too_long;
        logic              last;
    } out_item_t;

    // label command from front to back
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] n;
        logic             tl;
        logic             zf;
    } cmd_t;

    // bank release from back to front
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

`default_nettype wire

@@ rtl/dnse_ram.sv @@
`default_nettype none

module dnse_ram
    import dnse_pkg::*;
#(
    parameter int DEPTH = 2 * LABEL_MAX_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [BYTE_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/dnse_cmd_fifo.sv @@
`default_nettype none

module dnse_cmd_fifo
    import dnse_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire cmd_t wdata,
    output logic      q_full,
    input  wire logic rd,
    output logic      q_empty,
    output cmd_t      rdata
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wptr_reg, wptr_next;
    logic [CMDQ_PTR_W-1:0] rptr_reg, rptr_next;
    logic [CMDQ_PTR_W:0]   cnt_reg, cnt_next;
    logic                  do_wr, do_rd;

    // pointer and fill count update
    always_comb
    begin
        do_wr     = wr && !q_full;
        do_rd     = rd && !q_empty;
        wptr_next = do_wr ? wptr_reg + CMDQ_PTR_W'(1) : wptr_reg;
        rptr_next = do_rd ? rptr_reg + CMDQ_PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + (CMDQ_PTR_W+1)'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - (CMDQ_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    assign q_full  = (cnt_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rdata   = slot_reg[rptr_reg];

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (CMDQ_PTR_W+1)'(CMDQ_DEPTH))
        else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/dnse_front.sv @@
`default_nettype none

module dnse_front
    import dnse_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF,
    localparam int ADDR_W = $clog2(2 * LABEL_MAX)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire in_item_t          item,
    output logic                   mem_we,
    output logic      [ADDR_W-1:0] mem_waddr,
    output logic      [BYTE_W-1:0] mem_wdata,
    output logic                   q_wr,
    output cmd_t                   q_wdata,
    input  wire logic              q_full,
    input  wire rel_t              rel
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             bank_reg, bank_next;
    logic [1:0]       busy_reg, busy_next;
    logic             accept, is_char;

    // classify the accepted byte
    always_comb
    begin
        full    = busy_reg[bank_reg] || q_full;
        accept  = push && !full;
        is_char = (item.operation == OP_NAME_BYTE) && (item.name_byte != DOT_CHAR);

        count_next = count_reg;
        ovf_next   = ovf_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        mem_we     = 1'b0;
        q_wr       = 1'b0;

        q_wdata.bank = bank_reg;
        q_wdata.n    = count_reg;
        q_wdata.tl   = ovf_reg;
        q_wdata.zf   = (item.operation == OP_END);

        mem_waddr = bank_reg ? ADDR_W'(LABEL_MAX) + ADDR_W'(count_reg) : ADDR_W'(count_reg);
        mem_wdata = item.name_byte;

        // back has finished a bank
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept)
        begin
            if (is_char)
            begin
                if (count_reg < CNT_W'(LABEL_MAX))
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else
            begin
                // label closes: hand the bank to the back part
                q_wr                = 1'b1;
                busy_next[bank_reg] = 1'b1;
                bank_next           = !bank_reg;
                count_next          = '0;
                ovf_next            = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            bank_reg  <= 1'b0;
            busy_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
        end
    end

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LABEL_MAX))
        else $error("label count above limit");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !busy_reg[bank_reg])
        else $error("write into a bank still being emitted");
`endif

endmodule

`default_nettype wire

@@ rtl/dnse_back.sv @@
`default_nettype none

module dnse_back
    import dnse_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF,
    localparam int ADDR_W = $clog2(2 * LABEL_MAX)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire cmd_t              q_rdata,
    output logic                   q_rd,
    output logic                   mem_re,
    output logic      [ADDR_W-1:0] mem_raddr,
    input  wire logic [BYTE_W-1:0] mem_rdata,
    output rel_t                   rel,
    output logic                   empty,
    input  wire logic              pop,
    output out_item_t              result
);

    cmd_t             cmd_reg, cmd_next;
    logic             act_reg, act_next;
    logic             len_done_reg, len_done_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] em_reg, em_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;
    logic             slot_free, emit_len, load_data, len_fin, data_fin;

    // emission control
    always_comb
    begin
        slot_free = !out_valid_reg || pop;
        q_rd      = !act_reg && !q_empty;
        emit_len  = act_reg && !len_done_reg && slot_free;
        load_data = act_reg && rd_pend_reg && len_done_reg && slot_free;
        len_fin   = emit_len && (cmd_reg.n == '0);
        data_fin  = load_data && ((em_reg + CNT_W'(1)) == cmd_reg.n);
        mem_re    = act_reg && (rd_idx_reg != cmd_reg.n) && (!rd_pend_reg || load_data);
        mem_raddr = cmd_reg.bank ? ADDR_W'(LABEL_MAX) + ADDR_W'(rd_idx_reg)
                                 : ADDR_W'(rd_idx_reg);
        rel.valid = len_fin || data_fin;
        rel.bank  = cmd_reg.bank;

        cmd_next       = cmd_reg;
        act_next       = act_reg;
        len_done_next  = len_done_reg;
        rd_idx_next    = rd_idx_reg;
        em_next        = em_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;
        rd_pend_next   = mem_re ? 1'b1 : (load_data ? 1'b0 : rd_pend_reg);

        // take the next label command
        if (q_rd)
        begin
            cmd_next      = q_rdata;
            act_next      = 1'b1;
            len_done_next = 1'b0;
            rd_idx_next   = '0;
            em_next       = '0;
        end

        if (mem_re)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end

        // length byte first
        if (emit_len)
        begin
            out_next.out_byte     = BYTE_W'(cmd_reg.n);
            out_next.zero_follows = len_fin && cmd_reg.zf;
            out_next.too_long     = cmd_reg.tl;
            out_next.last         = len_fin;
            out_valid_next        = 1'b1;
            len_done_next         = 1'b1;
        end

        // then the stored characters
        if (load_data)
        begin
            out_next.out_byte     = mem_rdata;
            out_next.zero_follows = data_fin && cmd_reg.zf;
            out_next.too_long     = cmd_reg.tl;
            out_next.last         = data_fin;
            out_valid_next        = 1'b1;
            em_next               = em_reg + CNT_W'(1);
        end

        if (rel.valid)
        begin
            act_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            len_done_reg  <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            em_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            len_done_reg  <= len_done_next;
            rd_pend_reg   <= rd_pend_next;
            rd_idx_reg    <= rd_idx_next;
            em_reg        <= em_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

`ifndef ASSERT_OFF
    a_pend_active: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> act_reg)
        else $error("read pending without an active label");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        act_reg |-> (rd_idx_reg <= cmd_reg.n) && (em_reg <= rd_idx_reg))
        else $error("read index out of label bounds");

    a_release_last: assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |=> out_valid_reg && out_reg.last)
        else $error("bank released without a last result");
`endif

endmodule

`default_nettype wire

@@ rtl/dns_name_label_encoder.sv @@
// output: a label character gives no result; the length byte of a closed label
// passes the command queue, the command register and the result register after
// the dot or end of name is taken; its characters follow one per cycle from the
// label RAM read port while results are popped; labels go out one at a time.
// throughput: one input byte per cycle while a free label bank is available.
// reset: asynchronous, clears control state; the label RAM is not cleared.
`default_nettype none

module dns_name_label_encoder
    import dnse_pkg::*;
#(
    parameter int LABEL_MAX = LABEL_MAX_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_item_t  item,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      result
);

    localparam int ADDR_W = $clog2(2 * LABEL_MAX);

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [BYTE_W-1:0] mem_wdata, mem_rdata;
    logic              q_wr, q_full, q_rd, q_empty;
    cmd_t              q_wdata, q_rdata;
    rel_t              rel;

    // accept and classify name bytes
    dnse_front #(.LABEL_MAX(LABEL_MAX)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .q_wr      (q_wr),
        .q_wdata   (q_wdata),
        .q_full    (q_full),
        .rel       (rel)
    );

    // two label banks
    dnse_ram #(.DEPTH(2 * LABEL_MAX)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // label command queue
    dnse_cmd_fifo u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_rd),
        .q_empty (q_empty),
        .rdata   (q_rdata)
    );

    // emit length byte and characters
    dnse_back #(.LABEL_MAX(LABEL_MAX)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_rdata   (q_rdata),
        .q_rd      (q_rd),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .rel       (rel),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire
